// ----- rtl/core/imu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU frame parser package
// Shared constants, state type, command/status structs and the atan table.
// ----------------------------------------------------------------------------
package imu_pkg;

   localparam int SumWidthDefault    = 24;
   localparam int CordicStepsDefault = 16;
   localparam int PreShift           = 24;
   localparam int TabLen             = 24;
   // CORDIC working width: magnitude up to 2^31 shifted by 24, plus growth.
   localparam int CwWidth            = 58;
   localparam int AngWidth           = 25;

   localparam logic [7:0] HDR_BYTE   = 8'h55;
   localparam logic [7:0] TYPE_ACC   = 8'h51;
   localparam logic [7:0] TYPE_RATE  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;
   localparam logic [7:0] AVG_RESET  = 8'd20;
   localparam int         DegHalfTurn = 180;
   localparam logic [AngWidth-1:0] ANG_MAX = AngWidth'((DegHalfTurn / 2) * 65536);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PARSE,
      ST_ROLL,
      ST_TURN,
      ST_PITCH,
      ST_OUT
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic take_byte;   // store byte, advance parser
      logic start_roll;  // load CORDIC with roll operands
      logic start_pitch; // load CORDIC with pitch operands
      logic cordic_step; // run one CORDIC iteration
      logic save_roll;   // capture finished roll angle
      logic load_out;    // latch result into output register
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic frame_done;  // last byte was a good known frame
      logic need_tilt;   // that frame produces a tilt result
      logic cordic_last; // current iteration is the final one
   } status_type;

   function automatic logic [AngWidth-1:0] atan_entry(input logic [4:0] idx);
      logic [AngWidth-1:0] v;
      case (idx)
         5'd0:  v = 25'd2949120;
         5'd1:  v = 25'd1740967;
         5'd2:  v = 25'd919879;
         5'd3:  v = 25'd466945;
         5'd4:  v = 25'd234379;
         5'd5:  v = 25'd117304;
         5'd6:  v = 25'd58666;
         5'd7:  v = 25'd29335;
         5'd8:  v = 25'd14668;
         5'd9:  v = 25'd7334;
         5'd10: v = 25'd3667;
         5'd11: v = 25'd1833;
         5'd12: v = 25'd917;
         5'd13: v = 25'd458;
         5'd14: v = 25'd229;
         5'd15: v = 25'd115;
         5'd16: v = 25'd57;
         5'd17: v = 25'd29;
         5'd18: v = 25'd14;
         5'd19: v = 25'd7;
         5'd20: v = 25'd4;
         5'd21: v = 25'd2;
         5'd22: v = 25'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/core/imu_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU frame parser controller
// Sequences byte intake, the two CORDIC passes and the result transfer.
// ----------------------------------------------------------------------------
module imu_ctrl
   import imu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_PARSE;
         ST_PARSE: begin
            if (!status.frame_done) state_in = ST_IDLE;
            else if (status.need_tilt) state_in = ST_ROLL;
            else state_in = ST_OUT;
         end
         ST_ROLL:  if (status.cordic_last) state_in = ST_TURN;
         ST_TURN:  state_in = ST_PITCH;
         ST_PITCH: if (status.cordic_last) state_in = ST_OUT;
         ST_OUT:   if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.take_byte = req_valid;
         end
         ST_PARSE: begin
            cmd.start_roll = status.frame_done && status.need_tilt;
         end
         ST_ROLL: begin
            cmd.cordic_step = 1'b1;
         end
         ST_TURN: begin
            cmd.save_roll   = 1'b1;
            cmd.start_pitch = 1'b1;
         end
         ST_PITCH: begin
            cmd.cordic_step = 1'b1;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/imu_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU frame parser datapath
// Frame buffer, checksum, axis sums, one shared CORDIC unit, result register.
// ----------------------------------------------------------------------------
module imu_dp
   import imu_pkg::*;
#(
   parameter int SUM_WIDTH    = SumWidthDefault,
   parameter int CORDIC_STEPS = CordicStepsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_in_byte,
   input  logic               csr_we,
   input  logic [7:0]         csr_wdata,
   input  cmd_type            cmd,
   output status_type         status,
   output logic [1:0]         rsp_frame_kind,
   output logic signed [15:0] rsp_value_x,
   output logic signed [15:0] rsp_value_y,
   output logic signed [15:0] rsp_value_z,
   output logic signed [15:0] rsp_temperature_raw,
   output logic               rsp_tilt_valid,
   output logic signed [14:0] rsp_roll_centideg,
   output logic signed [14:0] rsp_pitch_centideg
);

   localparam int StepW = $clog2(CORDIC_STEPS + 1);

   logic [3:0]  pos_ff;
   logic [7:0]  bytes_ff [10];
   logic [7:0]  csum_ff;
   logic [7:0]  avg_ff;
   logic [7:0]  count_ff;
   logic signed [SUM_WIDTH-1:0] sx_ff, sy_ff, sz_ff;
   logic        done_ff, tilt_ff;

   logic signed [15:0] wx, wy, wz, wt;
   assign wx = {bytes_ff[3], bytes_ff[2]};
   assign wy = {bytes_ff[5], bytes_ff[4]};
   assign wz = {bytes_ff[7], bytes_ff[6]};
   assign wt = {bytes_ff[9], bytes_ff[8]};

   logic known;
   assign known = (bytes_ff[1] >= TYPE_ACC) && (bytes_ff[1] <= TYPE_ANGLE);

   // Parser: the last byte is judged here; the frame is evaluated next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         csum_ff <= '0;
         done_ff <= 1'b0;
         tilt_ff <= 1'b0;
      end else if (cmd.take_byte) begin
         done_ff <= 1'b0;
         tilt_ff <= 1'b0;
         if (pos_ff == 4'd0) begin
            if (req_in_byte == HDR_BYTE) begin
               csum_ff <= req_in_byte;
               pos_ff  <= 4'd1;
            end
         end else if (pos_ff < 4'd10) begin
            csum_ff <= csum_ff + req_in_byte;
            pos_ff  <= pos_ff + 4'd1;
         end else begin
            pos_ff  <= '0;
            done_ff <= (req_in_byte == csum_ff) && known;
            tilt_ff <= (req_in_byte == csum_ff) && (bytes_ff[1] == TYPE_ACC)
                       && (count_ff >= avg_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_byte && pos_ff < 4'd10 &&
          (pos_ff != 4'd0 || req_in_byte == HDR_BYTE))
         bytes_ff[pos_ff] <= req_in_byte;
   end

   assign status.frame_done = done_ff;
   assign status.need_tilt  = tilt_ff;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) avg_ff <= AVG_RESET;
      else if (csr_we) avg_ff <= csr_wdata;
   end

   // Axis sums, updated when the frame is evaluated.
   logic acc_frame;
   assign acc_frame = done_ff && (bytes_ff[1] == TYPE_ACC) && !cmd.take_byte;
   logic eval_ff;
   always_ff @(posedge clock) begin
      if (reset) eval_ff <= 1'b0;
      else eval_ff <= cmd.take_byte;
   end

   // Keep the sums through both tilt passes; they clear when the tilt result
   // is loaded into the result register.
   logic clear_sums;
   assign clear_sums = cmd.load_out && tilt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff <= '0; sy_ff <= '0; sz_ff <= '0; count_ff <= '0;
      end else if (clear_sums) begin
         sx_ff <= '0; sy_ff <= '0; sz_ff <= '0; count_ff <= '0;
      end else if (eval_ff && acc_frame && !tilt_ff) begin
         sx_ff    <= sx_ff + SUM_WIDTH'(wx);
         sy_ff    <= sy_ff + SUM_WIDTH'(wy);
         sz_ff    <= sz_ff + SUM_WIDTH'(wz);
         count_ff <= count_ff + 8'd1;
      end
   end

   // Shared CORDIC unit, one iteration per cycle.
   logic signed [CwWidth-1:0] cx_ff, cy_ff;
   logic signed [AngWidth+1:0] ang_ff;
   logic [StepW-1:0] step_ff;
   logic signed [SUM_WIDTH-1:0] num, den;
   logic signed [SUM_WIDTH:0]   num_e, den_e;
   logic [SUM_WIDTH:0] an, ad;

   assign num   = cmd.start_pitch ? sx_ff : sy_ff;
   assign den   = sz_ff;
   assign num_e = {num[SUM_WIDTH-1], num};
   assign den_e = {den[SUM_WIDTH-1], den};
   assign an    = num_e[SUM_WIDTH] ? (SUM_WIDTH+1)'(-num_e) : num_e;
   assign ad    = den_e[SUM_WIDTH] ? (SUM_WIDTH+1)'(-den_e) : den_e;

   logic signed [CwWidth-1:0] dy;
   logic signed [CwWidth-1:0] sxv, syv;
   assign sxv = cy_ff >>> step_ff;
   assign syv = cx_ff >>> step_ff;
   assign dy  = sxv;

   always_ff @(posedge clock) begin
      if (cmd.start_roll || cmd.start_pitch) begin
         cx_ff   <= CwWidth'(ad) <<< PreShift;
         cy_ff   <= CwWidth'(an) <<< PreShift;
         ang_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.cordic_step) begin
         step_ff <= step_ff + StepW'(1);
         if (!cy_ff[CwWidth-1]) begin
            cx_ff  <= cx_ff + dy;
            cy_ff  <= cy_ff - syv;
            ang_ff <= ang_ff + (AngWidth+2)'(atan_entry(5'(step_ff)));
         end else begin
            cx_ff  <= cx_ff - dy;
            cy_ff  <= cy_ff + syv;
            ang_ff <= ang_ff - (AngWidth+2)'(atan_entry(5'(step_ff)));
         end
      end
   end

   assign status.cordic_last = cmd.cordic_step &&
                               (step_ff == StepW'(CORDIC_STEPS - 1));

   // Angle finish: clamp, scale to centidegrees, apply signs.
   logic signed [AngWidth+1:0] ang_fin;
   logic [AngWidth-1:0] ang_cl;
   logic [AngWidth+7:0] prod;
   logic [14:0] mag;
   logic signed [14:0] angle;
   logic neg;
   always_comb begin
      ang_fin = ang_ff;
      if (ang_fin < 0) ang_cl = '0;
      else if (ang_fin > $signed({2'b00, ANG_MAX})) ang_cl = ANG_MAX;
      else ang_cl = AngWidth'(ang_fin);
      prod = (AngWidth+8)'(ang_cl) * (AngWidth+8)'(100) + (AngWidth+8)'(32768);
      mag  = 15'(prod >> 16);
      neg  = sz_ff[SUM_WIDTH-1] != (cmd.load_out ? sx_ff[SUM_WIDTH-1]
                                                 : sy_ff[SUM_WIDTH-1]);
      if (sz_ff == '0) begin
         if (cmd.load_out ? sx_ff == '0 : sy_ff == '0) angle = '0;
         else angle = (cmd.load_out ? sx_ff[SUM_WIDTH-1] : sy_ff[SUM_WIDTH-1])
                      ? -15'sd9000 : 15'sd9000;
      end else angle = neg ? -$signed(mag) : $signed(mag);
   end

   logic signed [14:0] roll_ff;
   always_ff @(posedge clock) begin
      if (cmd.save_roll) roll_ff <= angle;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_frame_kind      <= 2'(bytes_ff[1] - TYPE_ACC);
         rsp_value_x         <= wx;
         rsp_value_y         <= wy;
         rsp_value_z         <= wz;
         rsp_temperature_raw <= wt;
         rsp_tilt_valid      <= tilt_ff;
         rsp_roll_centideg   <= tilt_ff ? roll_ff : '0;
         rsp_pitch_centideg  <= tilt_ff ? -angle : '0;
      end
   end

endmodule

// ----- rtl/core/imu_frame_parser_tilt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU frame parser with accelerometer tilt
// Parses 11-byte sensor frames and reports raw words plus averaged tilt.
// ----------------------------------------------------------------------------
//  Channel   Ports                  Direction
//  req       req_valid/req_ready    byte in
//  rsp       rsp_valid/rsp_ready    frame result out
//  csr       csr_we/csr_wdata       average count write
//
//  A byte passes the parse state before the next is taken; the checksum byte
//  of a good frame also passes the output state; an acceleration frame that
//  completes a window runs the single shared CORDIC for roll and then pitch.
//  Reset clears the parser, sums and count; the register returns to 20.
//  A stalled result holds the block after the next frame until it is taken.
// ----------------------------------------------------------------------------
module imu_frame_parser_tilt
   import imu_pkg::*;
#(
   parameter int SUM_WIDTH    = SumWidthDefault,
   parameter int CORDIC_STEPS = CordicStepsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_frame_kind,
   output logic signed [15:0] rsp_value_x,
   output logic signed [15:0] rsp_value_y,
   output logic signed [15:0] rsp_value_z,
   output logic signed [15:0] rsp_temperature_raw,
   output logic               rsp_tilt_valid,
   output logic signed [14:0] rsp_roll_centideg,
   output logic signed [14:0] rsp_pitch_centideg,
   input  logic               csr_we,
   input  logic [7:0]         csr_wdata
);

   cmd_type    cmd;
   status_type status;

   imu_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   imu_dp #(.SUM_WIDTH(SUM_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock, .reset, .req_in_byte, .csr_we, .csr_wdata, .cmd, .status,
      .rsp_frame_kind, .rsp_value_x, .rsp_value_y, .rsp_value_z,
      .rsp_temperature_raw, .rsp_tilt_valid, .rsp_roll_centideg,
      .rsp_pitch_centideg
   );

endmodule

// ----- tb/tb_imu_frame_parser_tilt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU frame parser testbench
// Feeds byte streams of good, corrupt and noisy frames into the parser,
// predicts every frame result and the averaged tilt, and checks each one.
// ----------------------------------------------------------------------------
module tb_imu_frame_parser_tilt
   import imu_pkg::*;
;

   localparam int SumW      = 24;
   localparam int Steps     = 16;
   localparam int IdleLimit = 20000;

   typedef struct {
      logic [1:0]         kind;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [15:0] vz;
      logic signed [15:0] vt;
      logic               tilt;
      logic signed [14:0] roll;
      logic signed [14:0] pitch;
   } frame_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_in_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_frame_kind;
   logic signed [15:0] rsp_value_x;
   logic signed [15:0] rsp_value_y;
   logic signed [15:0] rsp_value_z;
   logic signed [15:0] rsp_temperature_raw;
   logic               rsp_tilt_valid;
   logic signed [14:0] rsp_roll_centideg;
   logic signed [14:0] rsp_pitch_centideg;
   logic               csr_we;
   logic [7:0]         csr_wdata;

   // Predictor state.
   logic [3:0]            pos;
   logic [7:0]            fbytes [10];
   logic [7:0]            csum;
   logic [SumW-1:0]       acc_x, acc_y, acc_z;
   logic [7:0]            acc_count;
   logic [7:0]            avg_count;

   logic [7:0]            pending_bytes [$];
   frame_result_type      expected_results [$];
   int                    error_count;
   int                    idle_cycles;
   int                    send_gap;
   int                    take_gap;
   bit                    hold_sender;
   logic                  req_ready_seen;

   imu_frame_parser_tilt u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_frame_kind(rsp_frame_kind), .rsp_value_x(rsp_value_x),
      .rsp_value_y(rsp_value_y), .rsp_value_z(rsp_value_z),
      .rsp_temperature_raw(rsp_temperature_raw), .rsp_tilt_valid(rsp_tilt_valid),
      .rsp_roll_centideg(rsp_roll_centideg), .rsp_pitch_centideg(rsp_pitch_centideg),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Gap length: mostly short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int s);
      return v >>> s;
   endfunction

   // Vectoring CORDIC angle of num/den in hundredths of a degree.
   function automatic int tilt_angle(longint num, longint den);
      longint an, ad, xv, yv, dx, dy, ang, mag;
      if (den == 0) return (num > 0) ? 9000 : ((num < 0) ? -9000 : 0);
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      xv = ad <<< PreShift;
      yv = an <<< PreShift;
      ang = 0;
      for (int i = 0; i < Steps && i < TabLen; i++) begin
         dx = floor_shr(yv, i);
         dy = floor_shr(xv, i);
         if (yv >= 0) begin
            xv += dx; yv -= dy; ang += longint'(atan_entry(5'(i)));
         end else begin
            xv -= dx; yv += dy; ang -= longint'(atan_entry(5'(i)));
         end
      end
      if (ang < 0) ang = 0;
      if (ang > longint'(DegHalfTurn / 2) * 65536) ang = longint'(DegHalfTurn / 2) * 65536;
      mag = (ang * 100 + 32768) >>> 16;
      if ((num < 0) != (den < 0)) mag = -mag;
      return int'(mag);
   endfunction

   function automatic logic signed [15:0] frame_word(int k);
      return {fbytes[3 + 2 * k], fbytes[2 + 2 * k]};
   endfunction

   // Advance the parser model by one byte and queue any frame result.
   task automatic predict_byte(logic [7:0] b);
      frame_result_type r;
      logic [7:0] ftype;
      if (pos == 4'd0) begin
         if (b == HDR_BYTE) begin
            fbytes[0] = b; csum = b; pos = 4'd1;
         end
         return;
      end
      if (pos < 4'd10) begin
         fbytes[pos] = b; csum = csum + b; pos = pos + 4'd1;
         return;
      end
      pos = 4'd0;
      if (b != csum) return;
      ftype = fbytes[1];
      if (ftype < TYPE_ACC || ftype > TYPE_ANGLE) return;
      r.kind = 2'(ftype - TYPE_ACC);
      r.vx = frame_word(0); r.vy = frame_word(1);
      r.vz = frame_word(2); r.vt = frame_word(3);
      r.tilt = 1'b0; r.roll = '0; r.pitch = '0;
      if (ftype == TYPE_ACC) begin
         if (acc_count >= avg_count) begin
            r.tilt  = 1'b1;
            r.roll  = 15'(tilt_angle(longint'($signed(acc_y)), longint'($signed(acc_z))));
            r.pitch = 15'(-tilt_angle(longint'($signed(acc_x)), longint'($signed(acc_z))));
            acc_x = '0; acc_y = '0; acc_z = '0; acc_count = '0;
         end else begin
            acc_x = acc_x + SumW'(r.vx);
            acc_y = acc_y + SumW'(r.vy);
            acc_z = acc_z + SumW'(r.vz);
            acc_count = acc_count + 8'd1;
         end
      end
      expected_results.push_back(r);
   endtask

   // Queue one frame; corrupt selects a broken checksum.
   task automatic push_frame(logic [7:0] ftype, logic [15:0] wx, logic [15:0] wy,
                             logic [15:0] wz, logic [15:0] wt, bit corrupt);
      logic [7:0] f [11];
      logic [7:0] s;
      f = '{HDR_BYTE, ftype, wx[7:0], wx[15:8], wy[7:0], wy[15:8],
            wz[7:0], wz[15:8], wt[7:0], wt[15:8], 8'h00};
      s = '0;
      for (int i = 0; i < 10; i++) s = s + f[i];
      f[10] = corrupt ? s + 8'(1 + $urandom_range(0, 254)) : s;
      foreach (f[i]) pending_bytes.push_back(f[i]);
   endtask

   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(16'($urandom_range(0, 4000)) - 16'd2000);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Wait until every byte is sent and every result has come back.
   task automatic drain();
      while (pending_bytes.size() != 0 || expected_results.size() != 0 || req_valid)
         @(posedge clock);
      repeat (2 * Steps + 40) @(posedge clock);
   endtask

   task automatic write_avg(logic [7:0] v);
      @(negedge clock);
      csr_we <= 1'b1; csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      avg_count = v;
   endtask

   // Driver: one byte transfer at a time from the pending queue.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_byte(req_in_byte);
         send_gap = pick_gap();
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready_seen) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!hold_sender && pending_bytes.size() != 0) begin
            req_valid <= 1'b1;
            req_in_byte <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Track whether the current byte was taken at the last rising edge.
   always @(posedge clock) req_ready_seen <= req_valid && req_ready;

   // Monitor: compare each result transfer with the oldest prediction.
   always @(posedge clock) begin
      frame_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("unexpected result transfer");
            error_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_frame_kind !== e.kind) report_mismatch("kind", rsp_frame_kind, e.kind);
            if (rsp_value_x !== e.vx) report_mismatch("value_x", rsp_value_x, e.vx);
            if (rsp_value_y !== e.vy) report_mismatch("value_y", rsp_value_y, e.vy);
            if (rsp_value_z !== e.vz) report_mismatch("value_z", rsp_value_z, e.vz);
            if (rsp_temperature_raw !== e.vt)
               report_mismatch("temperature", rsp_temperature_raw, e.vt);
            if (rsp_tilt_valid !== e.tilt) report_mismatch("tilt_valid", rsp_tilt_valid, e.tilt);
            if (rsp_roll_centideg !== e.roll) report_mismatch("roll", rsp_roll_centideg, e.roll);
            if (rsp_pitch_centideg !== e.pitch)
               report_mismatch("pitch", rsp_pitch_centideg, e.pitch);
         end
      end
   end

   // Receiver stalls at random.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap <= 0;
      end else if (take_gap > 0) begin
         take_gap <= take_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) take_gap <= pick_gap();
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [7:0] settings [5];
      int frames;
      req_valid = 1'b0; req_in_byte = '0; rsp_ready = 1'b0;
      csr_we = 1'b0; csr_wdata = '0;
      error_count = 0; idle_cycles = 0; send_gap = 0; take_gap = 0;
      hold_sender = 1'b0; req_ready_seen = 1'b0;
      pos = '0; csum = '0; acc_x = '0; acc_y = '0; acc_z = '0;
      acc_count = '0; avg_count = AVG_RESET;
      foreach (fbytes[i]) fbytes[i] = '0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: noise before a header, each type, extremes, bad frames.
      write_avg(8'd2);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      push_frame(TYPE_ACC, 16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 0);
      push_frame(TYPE_RATE, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFF, 0);
      push_frame(TYPE_ANGLE, 16'h0001, 16'h0000, 16'h8000, 16'h0000, 0);
      push_frame(TYPE_ACC, 16'h0000, 16'h0000, 16'h0000, 16'h1234, 0);
      push_frame(TYPE_ACC, 16'h0100, 16'h0200, 16'h0300, 16'h0000, 0);
      push_frame(8'h50, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 0);
      push_frame(8'h54, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 0);
      push_frame(TYPE_RATE, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 1);
      // Zero sums on z only: the tilt goes to the quarter-turn limits.
      push_frame(TYPE_ACC, 16'h0100, 16'hFF00, 16'h0000, 16'h0000, 0);
      push_frame(TYPE_ACC, 16'h0100, 16'hFF00, 16'h0000, 16'h0000, 0);
      push_frame(TYPE_ACC, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
      drain();

      // Random phases over several averaging counts, extremes among them.
      settings = '{8'd1, 8'd255, 8'd5, 8'd20, 8'd3};
      foreach (settings[p]) begin
         write_avg(settings[p]);
         frames = (settings[p] == 8'd255) ? 40 : 16;
         for (int n = 0; n < frames; n++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 70)
               push_frame(TYPE_ACC, rand_word(), rand_word(), rand_word(), rand_word(), 0);
            else if (r < 85)
               push_frame(8'(TYPE_RATE + $urandom_range(0, 1)), rand_word(), rand_word(),
                          rand_word(), rand_word(), 0);
            else if (r < 92)
               push_frame(8'($urandom), rand_word(), rand_word(), rand_word(), rand_word(),
                          $urandom_range(0, 1));
            else
               pending_bytes.push_back(8'($urandom));
         end
         // Hold the sender once until every result is in.
         if (p == 2) begin
            hold_sender = 1'b1;
            while (expected_results.size() != 0 || req_valid) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain();
      end

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
